// ===== design/sorted_unique_key_table_macros.svh =====
// Assertion macros used by the table's datapath.
`ifndef SORTED_UNIQUE_KEY_TABLE_MACROS_SVH
`define SORTED_UNIQUE_KEY_TABLE_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define SUK_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define SUK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/suk_pkg.sv =====
package suk_pkg;

  localparam int DEPTH = 32;
  localparam int KEY_W = 16;
  localparam int PAY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_LOOKUP,
    CMD_NOP
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_DUP,
    ST_FULL,
    ST_MISSING
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_up;
    logic shift_dn;
    logic write_new;
    logic result;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic go_up;
    logic go_dn;
    logic shift_done;
    logic out_free;
  } stat_t;

endpackage

// ===== design/suk_ctrl.sv =====
module suk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  suk_pkg::stat_t stat,
  output suk_pkg::ctl_t  ctl,
  output logic           in_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_WRITE_NEW,
    S_SHIFT_DN,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.go_up) begin
            state_nxt = S_SHIFT_UP;
          end else if (stat.go_dn) begin
            state_nxt = S_SHIFT_DN;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SHIFT_UP: begin
        if (stat.shift_done) begin
          state_nxt = S_WRITE_NEW;
        end
      end
      S_WRITE_NEW: begin
        state_nxt = S_RESULT;
      end
      S_SHIFT_DN: begin
        if (stat.shift_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl.load      = (state_r == S_IDLE);
    ctl.scan      = (state_r == S_SCAN);
    ctl.shift_up  = (state_r == S_SHIFT_UP);
    ctl.shift_dn  = (state_r == S_SHIFT_DN);
    ctl.write_new = (state_r == S_WRITE_NEW);
    ctl.result    = (state_r == S_RESULT);
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== design/suk_datapath.sv =====
`include "sorted_unique_key_table_macros.svh"

module suk_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [suk_pkg::CMD_W-1:0] in_cmd,
  input  logic [suk_pkg::KEY_W-1:0] in_key,
  input  logic [suk_pkg::PAY_W-1:0] in_payload,
  input  suk_pkg::ctl_t             ctl,
  output suk_pkg::stat_t            stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [suk_pkg::ST_W-1:0]  out_status,
  output logic [suk_pkg::IDX_W-1:0] out_position,
  output logic [suk_pkg::PAY_W-1:0] out_payload_out,
  output logic [suk_pkg::CNT_W-1:0] out_count
);

  suk_pkg::entry_t mem [suk_pkg::DEPTH];
  suk_pkg::entry_t rdata_r;
  suk_pkg::entry_t wr_data;
  logic [suk_pkg::IDX_W-1:0] rd_addr;
  logic [suk_pkg::IDX_W-1:0] wr_addr;
  logic                      wr_en;

  suk_pkg::op_t              op_r;
  logic [suk_pkg::KEY_W-1:0] key_r;
  logic [suk_pkg::PAY_W-1:0] pay_r;

  logic [suk_pkg::CNT_W-1:0] count_r;
  logic [suk_pkg::CNT_W-1:0] sidx_r;
  logic [suk_pkg::CNT_W-1:0] at_r;
  logic [suk_pkg::CNT_W-1:0] mptr_r;
  logic [suk_pkg::CNT_W-1:0] mptr_dec;
  logic [suk_pkg::CNT_W-1:0] mptr_inc;
  logic [suk_pkg::IDX_W-1:0] cidx_r;
  logic [suk_pkg::IDX_W-1:0] mdst_r;
  logic                      cvld_r;
  logic                      mvld_r;
  logic                      out_valid_r;

  logic                      cmp_stop;
  logic                      scan_end;
  logic                      scan_hit;
  logic [suk_pkg::CNT_W-1:0] scan_at;
  logic                      full;
  logic                      issue_scan;
  logic                      up_issue;
  logic                      dn_issue;
  logic                      shift_done;
  logic                      load_out;
  logic                      out_free;
  logic                      go_up;
  logic                      go_dn;

  suk_pkg::status_t          res_status_r;
  suk_pkg::status_t          res_status_nxt;
  logic [suk_pkg::IDX_W-1:0] res_pos_r;
  logic [suk_pkg::IDX_W-1:0] res_pos_nxt;
  logic [suk_pkg::PAY_W-1:0] res_pay_r;
  logic [suk_pkg::PAY_W-1:0] res_pay_nxt;

  logic [suk_pkg::ST_W-1:0]  out_status_r;
  logic [suk_pkg::IDX_W-1:0] out_position_r;
  logic [suk_pkg::PAY_W-1:0] out_payload_r;
  logic [suk_pkg::CNT_W-1:0] out_count_r;

  // The scan reads one entry a cycle and compares it in the next cycle.
  assign cmp_stop   = cvld_r && (rdata_r.key >= key_r);
  assign scan_end   = cmp_stop || (!cvld_r && (sidx_r == count_r));
  assign scan_hit   = cmp_stop && (rdata_r.key == key_r);
  assign scan_at    = cmp_stop ? {1'b0, cidx_r} : count_r;
  assign full       = (count_r == suk_pkg::CNT_W'(suk_pkg::DEPTH));
  assign issue_scan = ctl.scan && !cmp_stop && (sidx_r < count_r);

  assign go_up = scan_end && (op_r == suk_pkg::CMD_INSERT) && !scan_hit && !full;
  assign go_dn = scan_end && (op_r == suk_pkg::CMD_DELETE) && scan_hit;

  assign mptr_dec = mptr_r - 1'b1;
  assign mptr_inc = mptr_r + 1'b1;
  assign up_issue = ctl.shift_up && (mptr_r > at_r);
  assign dn_issue = ctl.shift_dn && (mptr_inc < count_r);
  assign shift_done = !mvld_r && !up_issue && !dn_issue;

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = ctl.result && out_free;

  always_comb begin
    stat.scan_done  = scan_end;
    stat.go_up      = go_up;
    stat.go_dn      = go_dn;
    stat.shift_done = shift_done;
    stat.out_free   = out_free;
  end

  always_comb begin
    priority if (ctl.shift_up) begin
      rd_addr = mptr_dec[suk_pkg::IDX_W-1:0];
    end else if (ctl.shift_dn) begin
      rd_addr = mptr_inc[suk_pkg::IDX_W-1:0];
    end else begin
      rd_addr = sidx_r[suk_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    wr_en = mvld_r || ctl.write_new;
    if (ctl.write_new) begin
      wr_addr = at_r[suk_pkg::IDX_W-1:0];
      wr_data = '{key: key_r, payload: pay_r};
    end else begin
      wr_addr = mdst_r;
      wr_data = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    res_status_nxt = suk_pkg::ST_OK;
    res_pos_nxt    = '0;
    res_pay_nxt    = '0;
    unique case (op_r)
      suk_pkg::CMD_INSERT: begin
        if (scan_hit) begin
          res_status_nxt = suk_pkg::ST_DUP;
        end else if (full) begin
          res_status_nxt = suk_pkg::ST_FULL;
        end else begin
          res_pos_nxt = scan_at[suk_pkg::IDX_W-1:0];
        end
      end
      suk_pkg::CMD_DELETE, suk_pkg::CMD_LOOKUP: begin
        if (!scan_hit) begin
          res_status_nxt = suk_pkg::ST_MISSING;
        end else begin
          res_pos_nxt = scan_at[suk_pkg::IDX_W-1:0];
          res_pay_nxt = rdata_r.payload;
        end
      end
      suk_pkg::CMD_NOP: begin
        res_status_nxt = suk_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cvld_r      <= 1'b0;
      mvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cvld_r <= issue_scan;
      mvld_r <= up_issue || dn_issue;
      if (ctl.write_new) begin
        count_r <= count_r + 1'b1;
      end else if (ctl.shift_dn && shift_done) begin
        count_r <= count_r - 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && in_valid) begin
      op_r   <= suk_pkg::op_t'(in_cmd);
      key_r  <= in_key;
      pay_r  <= in_payload;
      sidx_r <= '0;
    end
    if (issue_scan) begin
      sidx_r <= sidx_r + 1'b1;
      cidx_r <= sidx_r[suk_pkg::IDX_W-1:0];
    end
    if (ctl.scan && scan_end) begin
      at_r         <= scan_at;
      mptr_r       <= go_up ? count_r : scan_at;
      res_status_r <= res_status_nxt;
      res_pos_r    <= res_pos_nxt;
      res_pay_r    <= res_pay_nxt;
    end
    if (up_issue) begin
      mptr_r <= mptr_dec;
      mdst_r <= mptr_r[suk_pkg::IDX_W-1:0];
    end
    if (dn_issue) begin
      mptr_r <= mptr_inc;
      mdst_r <= mptr_r[suk_pkg::IDX_W-1:0];
    end
    if (load_out) begin
      out_status_r   <= res_status_r;
      out_position_r <= res_pos_r;
      out_payload_r  <= res_pay_r;
      out_count_r    <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_position_r;
  assign out_payload_out = out_payload_r;
  assign out_count       = out_count_r;

  `SUK_IMPLY(a_no_insert_when_full, ctl.write_new, !full, "New entry written into a full table.")
  `SUK_IMPLY(a_scan_in_range, ctl.scan, sidx_r <= count_r, "Scan ran past the valid entries.")
  `SUK_IMPLY(a_no_write_idle, ctl.scan || ctl.result || ctl.load, !wr_en, "Table written outside a move.")
  `SUK_IMPLY(a_count_step, $past(rst_n), (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1), "Count moved by more than one.")
  `SUK_CHECK(a_count_bound, count_r <= suk_pkg::CNT_W'(suk_pkg::DEPTH), "Count exceeds the depth.")

endmodule

// ===== design/sorted_unique_key_table.sv =====
// The scan reads one entry per cycle, then an insert or delete moves one entry per cycle;
// together they cover the table once, and the longest case is an insert at the front of
// DEPTH - 1 entries. The table takes one word at a time: the next word is taken only after
// the previous result is loaded into the output, which can wait under out_stall.
// Reset clears the entry count, the controller and the output valid; entries are undefined.
module sorted_unique_key_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [suk_pkg::CMD_W-1:0] in_cmd,
  input  logic [suk_pkg::KEY_W-1:0] in_key,
  input  logic [suk_pkg::PAY_W-1:0] in_payload,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [suk_pkg::ST_W-1:0]  out_status,
  output logic [suk_pkg::IDX_W-1:0] out_position,
  output logic [suk_pkg::PAY_W-1:0] out_payload_out,
  output logic [suk_pkg::CNT_W-1:0] out_count
);

  suk_pkg::ctl_t  ctl;
  suk_pkg::stat_t stat;

  suk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  suk_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .ctl             (ctl),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_payload_out (out_payload_out),
    .out_count       (out_count)
  );

endmodule
